// ===== sv/rnea_pkg.sv =====
// Shared types and constants for the ring neighbor exclusion arbiter.
// Seat state codes, request codes, index widths and ring direction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rnea_pkg;

    localparam int MAX_SEATS     = 256;
    localparam int MIN_SEATS     = 2;
    localparam int NUM_SEATS_RST = 5;

    localparam int CFG_W   = 9;
    localparam int SEAT_W  = 8;
    localparam int IDX_W   = $clog2(MAX_SEATS);
    localparam int CNT_W   = $clog2(MAX_SEATS + 1);
    localparam int SAT_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_PAD_W  = OUT_DATA_W - (2 * SEAT_W + 2);

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        ST_THINKING = 2'd0,
        ST_HUNGRY   = 2'd1,
        ST_EATING   = 2'd2
    } t_seat_st;

    typedef enum logic {
        DIR_LEFT  = 1'b0,
        DIR_RIGHT = 1'b1
    } t_dir;

    typedef struct packed {
        t_idx idx;
        t_dir dir;
    } t_ring_req;

endpackage

`default_nettype wire

// ===== sv/rnea_ring.sv =====
// Ring neighbor unit: one compare-and-subtract that wraps a seat index
// left or right around a ring of the given seat count.
// Depends on rnea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rnea_ring (
    input  wire rnea_pkg::t_ring_req i_req,
    input  wire rnea_pkg::t_cnt      i_count,
    output rnea_pkg::t_idx           o_neighbor
);

    rnea_pkg::t_cnt w_base;
    rnea_pkg::t_cnt w_sum;
    rnea_pkg::t_cnt w_res;

    assign w_base = rnea_pkg::CNT_W'(i_req.idx);

    always_comb begin
        unique case (i_req.dir)
            rnea_pkg::DIR_LEFT: begin
                w_sum = (w_base == '0) ? i_count : w_base;
                w_res = w_sum - rnea_pkg::CNT_W'(1);
            end
            rnea_pkg::DIR_RIGHT: begin
                w_sum = w_base + rnea_pkg::CNT_W'(1);
                w_res = (w_sum >= i_count) ? (w_sum - i_count) : w_sum;
            end
            default: begin
                w_sum = w_base;
                w_res = w_base;
            end
        endcase
    end

    assign o_neighbor = w_res[rnea_pkg::IDX_W-1:0];

endmodule

`default_nettype wire

// ===== sv/ring_neighbor_exclusion_arbiter_core.sv =====
// Top level of the ring neighbor exclusion arbiter: sequencer, seat state
// memory, seat count register and the request / result stream ports.
// Depends on rnea_pkg and rnea_ring.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   i_s_axis_tvalid/o_..tready tdata: seat; tuser: opcode
// m_axis    out  o_m_axis_tvalid/i_..tready tdata: grants; tuser: bad_seat
// cfg       in   i_cfg_wr_en                i_cfg_wr_data: num_seats
//
// After reset a clearing pass writes every seat to thinking, with the input
// not ready; config writes are taken during it. An accepted acquire steps
// through WRITE, RD_C, RD_L, RD_R and DECIDE to OUT; a release runs RD_C to
// DECIDE once per neighbor; a bad seat goes straight to OUT. The seat memory
// is read one entry a cycle through the shared ring neighbor unit. The result
// is held until taken; the input is ready again the cycle after it is taken.
`timescale 1ns / 1ps
`default_nettype none

module ring_neighbor_exclusion_arbiter_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire [rnea_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // seat[7:0]
    input  wire [rnea_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // opcode[0]
    input  wire                              i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // first_valid[0], first_seat[8:1], second_valid[9], second_seat[17:10]
    output logic [rnea_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // bad_seat[0]
    output logic                             o_m_axis_tuser
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_RD_C,
        S_RD_L,
        S_RD_R,
        S_DECIDE,
        S_OUT
    } t_state;

    t_state                      r_state;
    logic [rnea_pkg::CFG_W-1:0]  r_num_seats;
    rnea_pkg::t_idx              r_clr;
    logic                        r_op;
    logic                        r_phase;
    rnea_pkg::t_idx              r_seat;
    rnea_pkg::t_idx              r_cur;
    rnea_pkg::t_seat_st          r_c_st;
    rnea_pkg::t_seat_st          r_l_st;
    rnea_pkg::t_seat_st          r_rd;
    logic                        r_fv;
    rnea_pkg::t_idx              r_fs;
    logic                        r_sv;
    rnea_pkg::t_idx              r_ss;
    logic                        r_bad;

    rnea_pkg::t_seat_st          r_mem [rnea_pkg::MAX_SEATS];

    logic [rnea_pkg::SAT_W-1:0]  w_ns_wide;
    logic [rnea_pkg::SAT_W-1:0]  w_n_sat;
    rnea_pkg::t_cnt              w_count;
    logic                        w_bad;
    rnea_pkg::t_ring_req         w_ring_req;
    rnea_pkg::t_idx              w_neighbor;
    rnea_pkg::t_idx              w_raddr;
    logic                        w_we;
    rnea_pkg::t_idx              w_waddr;
    rnea_pkg::t_seat_st          w_wdata;
    logic                        w_grant;

    // Seat count in use, saturated to the legal range
    assign w_ns_wide = rnea_pkg::SAT_W'(r_num_seats);

    always_comb begin
        priority if (w_ns_wide < rnea_pkg::SAT_W'(rnea_pkg::MIN_SEATS)) begin
            w_n_sat = rnea_pkg::SAT_W'(rnea_pkg::MIN_SEATS);
        end else if (w_ns_wide > rnea_pkg::SAT_W'(rnea_pkg::MAX_SEATS)) begin
            w_n_sat = rnea_pkg::SAT_W'(rnea_pkg::MAX_SEATS);
        end else begin
            w_n_sat = w_ns_wide;
        end
    end

    assign w_count = w_n_sat[rnea_pkg::CNT_W-1:0];
    assign w_bad   = rnea_pkg::SAT_W'(i_s_axis_tdata) >= w_n_sat;

    always_comb begin
        unique case (r_state)
            S_WRITE:  w_ring_req = '{idx: r_seat, dir: rnea_pkg::DIR_LEFT};
            S_RD_R:   w_ring_req = '{idx: r_cur,  dir: rnea_pkg::DIR_RIGHT};
            S_DECIDE: w_ring_req = '{idx: r_seat, dir: rnea_pkg::DIR_RIGHT};
            default:  w_ring_req = '{idx: r_cur,  dir: rnea_pkg::DIR_LEFT};
        endcase
    end

    rnea_ring u_ring (
        .i_req      (w_ring_req),
        .i_count    (w_count),
        .o_neighbor (w_neighbor)
    );

    assign w_raddr = (r_state == S_RD_C) ? r_cur : w_neighbor;
    assign w_grant = (r_c_st == rnea_pkg::ST_HUNGRY) &&
                     (r_l_st != rnea_pkg::ST_EATING) &&
                     (r_rd != rnea_pkg::ST_EATING);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = rnea_pkg::ST_EATING;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = rnea_pkg::ST_THINKING;
            end
            S_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_seat;
                w_wdata = (r_op == rnea_pkg::OP_RELEASE) ? rnea_pkg::ST_THINKING
                                                         : rnea_pkg::ST_HUNGRY;
            end
            S_DECIDE: begin
                w_we    = w_grant;
                w_waddr = r_cur;
                w_wdata = rnea_pkg::ST_EATING;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_seats <= rnea_pkg::CFG_W'(rnea_pkg::NUM_SEATS_RST);
        end else if (i_cfg_wr_en) begin
            r_num_seats <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_phase <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + rnea_pkg::IDX_W'(1);
                    if (r_clr == rnea_pkg::IDX_W'(rnea_pkg::MAX_SEATS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op    <= i_s_axis_tuser;
                        r_seat  <= rnea_pkg::IDX_W'(i_s_axis_tdata);
                        r_bad   <= w_bad;
                        r_fv    <= 1'b0;
                        r_fs    <= '0;
                        r_sv    <= 1'b0;
                        r_ss    <= '0;
                        r_phase <= 1'b0;
                        r_state <= w_bad ? S_OUT : S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_cur   <= (r_op == rnea_pkg::OP_RELEASE) ? w_neighbor : r_seat;
                    r_state <= S_RD_C;
                end
                S_RD_C: begin
                    r_state <= S_RD_L;
                end
                S_RD_L: begin
                    r_c_st  <= r_rd;
                    r_state <= S_RD_R;
                end
                S_RD_R: begin
                    r_l_st  <= r_rd;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_grant) begin
                        if (r_phase) begin
                            r_sv <= 1'b1;
                            r_ss <= r_cur;
                        end else begin
                            r_fv <= 1'b1;
                            r_fs <= r_cur;
                        end
                    end
                    if ((r_op == rnea_pkg::OP_RELEASE) && !r_phase) begin
                        r_phase <= 1'b1;
                        r_cur   <= w_neighbor;
                        r_state <= S_RD_C;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {{rnea_pkg::OUT_PAD_W{1'b0}},
                              rnea_pkg::SEAT_W'(r_ss), r_sv,
                              rnea_pkg::SEAT_W'(r_fs), r_fv};
    assign o_m_axis_tuser  = r_bad;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready while a word is in work");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input ready while a result waits");

    a_bad_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (!o_m_axis_tdata[0] && !o_m_axis_tdata[9]))
        else $error("grant reported on a rejected seat");

    a_acq_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_op == rnea_pkg::OP_ACQUIRE)) |-> !r_sv)
        else $error("second grant on an acquire");

endmodule

`default_nettype wire

// ===== tb/rnea_grant_checker.sv =====
// Checker for the ring neighbor exclusion arbiter: watches the config port and
// both word streams, predicts every grant word, and compares it field by field.
// Depends on rnea_pkg.
`timescale 1ns / 1ps

module rnea_grant_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire [rnea_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input  wire                              i_s_axis_tvalid,
    input  wire                              i_s_axis_tready,
    input  wire [rnea_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input  wire                              i_s_axis_tuser,
    input  wire                              i_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    input  wire [rnea_pkg::OUT_DATA_W-1:0]   i_m_axis_tdata,
    input  wire                              i_m_axis_tuser,
    output int                               o_fail_count,
    output int                               o_pending
);

    import rnea_pkg::*;

    typedef struct packed {
        logic              first_valid;
        logic [SEAT_W-1:0] first_seat;
        logic              second_valid;
        logic [SEAT_W-1:0] second_seat;
        logic              bad_seat;
    } grant_word_t;

    t_seat_st          seat_tbl [MAX_SEATS];
    logic [CFG_W-1:0]  seat_count;
    grant_word_t       grants_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int seats_live();
        int n;
        n = int'(seat_count);
        if (n < MIN_SEATS) n = MIN_SEATS;
        if (n > MAX_SEATS) n = MAX_SEATS;
        return n;
    endfunction

    function automatic int ring_prev(int i, int n);
        return (i == 0) ? n - 1 : i - 1;
    endfunction

    function automatic int ring_next(int i, int n);
        return (i + 1 >= n) ? i + 1 - n : i + 1;
    endfunction

    function automatic bit grant_if_free(int i, int n);
        if (seat_tbl[ring_prev(i, n)] != ST_EATING && seat_tbl[i] == ST_HUNGRY &&
            seat_tbl[ring_next(i, n)] != ST_EATING) begin
            seat_tbl[i] = ST_EATING;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic grant_word_t predict_grants(logic op, logic [SEAT_W-1:0] seat);
        grant_word_t g;
        int          n;
        int          l;
        int          r;
        g = '0;
        n = seats_live();
        if (int'(seat) >= n) begin
            g.bad_seat = 1'b1;
        end else if (op == OP_ACQUIRE) begin
            seat_tbl[seat] = ST_HUNGRY;
            if (grant_if_free(int'(seat), n)) begin
                g.first_valid = 1'b1;
                g.first_seat  = seat;
            end
        end else begin
            l = ring_prev(int'(seat), n);
            r = ring_next(int'(seat), n);
            seat_tbl[seat] = ST_THINKING;
            if (grant_if_free(l, n)) begin
                g.first_valid = 1'b1;
                g.first_seat  = SEAT_W'(l);
            end
            if (grant_if_free(r, n)) begin
                g.second_valid = 1'b1;
                g.second_seat  = SEAT_W'(r);
            end
        end
        return g;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        grant_word_t due;
        if (!i_rst_n) begin
            foreach (seat_tbl[i]) seat_tbl[i] = ST_THINKING;
            seat_count = CFG_W'(NUM_SEATS_RST);
            grants_due.delete();
        end else begin
            if (i_cfg_wr_en) seat_count = i_cfg_wr_data;
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (grants_due.size() == 0) begin
                    $error("grant word with no request pending: tdata %h tuser %b",
                           i_m_axis_tdata, i_m_axis_tuser);
                    o_fail_count++;
                end else begin
                    due = grants_due.pop_front();
                    check_field("first_valid", due.first_valid, i_m_axis_tdata[0]);
                    check_field("first_seat", due.first_seat, i_m_axis_tdata[8:1]);
                    check_field("second_valid", due.second_valid, i_m_axis_tdata[9]);
                    check_field("second_seat", due.second_seat, i_m_axis_tdata[17:10]);
                    check_field("bad_seat", due.bad_seat, i_m_axis_tuser);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                grants_due.push_back(predict_grants(i_s_axis_tuser, i_s_axis_tdata));
        end
        o_pending = grants_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the ring neighbor exclusion arbiter: clock, reset, request
// stimulus, seat count writes, back-pressure, watchdog and verdict.
// Depends on rnea_pkg, ring_neighbor_exclusion_arbiter_core and rnea_grant_checker.
`timescale 1ns / 1ps

module tb_top;

    import rnea_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_WORDS = 50;
    localparam int NUM_PHASES  = 8;

    typedef enum int {
        MODE_STEADY,
        MODE_SEND_GAPS,
        MODE_RECV_STALLS,
        MODE_BOTH
    } traffic_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    int                     fail_count;
    int                     pending;
    traffic_mode_t          traffic_mode;
    int                     cur_seats;

    wire s_fire = s_tvalid && s_tready;
    wire m_fire = m_tvalid && m_tready;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ring_neighbor_exclusion_arbiter_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    rnea_grant_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(negedge clk) begin
        case (traffic_mode)
            MODE_RECV_STALLS: m_tready <= ($urandom_range(0, 99) >= 72);
            MODE_BOTH:        m_tready <= ($urandom_range(0, 99) >= 7);
            default:          m_tready <= 1'b1;
        endcase
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (s_fire || m_fire) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit sender_idle();
        case (traffic_mode)
            MODE_SEND_GAPS: return $urandom_range(0, 99) < 72;
            MODE_BOTH:      return $urandom_range(0, 99) < 7;
            default:        return 1'b0;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic op, input logic [SEAT_W-1:0] seat);
        while (sender_idle()) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seat;
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic set_seats(input int value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_seats = (value < MIN_SEATS) ? MIN_SEATS : (value > MAX_SEATS) ? MAX_SEATS : value;
    endtask

    initial begin : stimulus
        int                seat_plan [NUM_PHASES];
        int                window;
        int                pick;
        logic [SEAT_W-1:0] seat;
        logic              op;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_ACQUIRE;
        m_tready     = 1'b0;
        traffic_mode = MODE_STEADY;
        cur_seats    = NUM_SEATS_RST;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // five seats from reset
        send_word(OP_ACQUIRE, 8'd0);
        send_word(OP_ACQUIRE, 8'd1);
        send_word(OP_ACQUIRE, 8'd4);
        send_word(OP_ACQUIRE, 8'd2);
        send_word(OP_RELEASE, 8'd0);
        send_word(OP_RELEASE, 8'd2);
        send_word(OP_ACQUIRE, 8'd1);
        send_word(OP_ACQUIRE, 8'd3);
        send_word(OP_ACQUIRE, 8'd3);
        send_word(OP_RELEASE, 8'd3);
        send_word(OP_ACQUIRE, 8'd5);
        send_word(OP_RELEASE, 8'd255);
        send_word(OP_RELEASE, 8'd4);
        send_word(OP_RELEASE, 8'd1);

        // two seats: both neighbors are the same seat
        set_seats(2);
        send_word(OP_ACQUIRE, 8'd0);
        send_word(OP_ACQUIRE, 8'd1);
        send_word(OP_RELEASE, 8'd0);
        send_word(OP_ACQUIRE, 8'd2);

        set_seats(0);
        send_word(OP_ACQUIRE, 8'd1);
        send_word(OP_RELEASE, 8'd1);

        set_seats(511);
        send_word(OP_ACQUIRE, 8'd255);
        send_word(OP_ACQUIRE, 8'd0);
        send_word(OP_RELEASE, 8'd255);

        seat_plan = '{2, 3, 5, 7, 0, 16, 511, 0};
        seat_plan[NUM_PHASES-1] = $urandom_range(2, 256);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_seats(seat_plan[phase]);
            traffic_mode = traffic_mode_t'(phase % 4);
            window = $urandom_range(0, cur_seats - 1);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k % 16 == 0) window = $urandom_range(0, cur_seats - 1);
                pick = $urandom_range(0, 99);
                if (pick < 10 && cur_seats < MAX_SEATS)
                    seat = SEAT_W'($urandom_range(cur_seats, 255));
                else if (pick < 30)
                    seat = SEAT_W'($urandom_range(0, cur_seats - 1));
                else
                    seat = SEAT_W'((window + $urandom_range(0, 4)) % cur_seats);
                op = ($urandom_range(0, 99) < 55) ? OP_ACQUIRE : OP_RELEASE;
                if ($urandom_range(0, 39) == 0) wait_drained();
                send_word(op, seat);
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rnea_pkg.sv
sv/rnea_ring.sv
sv/ring_neighbor_exclusion_arbiter_core.sv
tb/rnea_grant_checker.sv
tb/tb_top.sv
